// ===== hdl/sip_pkg.sv =====
// sip_pkg: shared types, codes and helpers of the suffixed integer parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sip_pkg;

	// magnitude limits for a signed 64-bit result
	localparam logic [63:0] PosLimit = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;

	// configuration register indexes
	localparam logic CfgMinIdx = 1'b0;
	localparam logic CfgMaxIdx = 1'b1;

	typedef enum logic [3:0] {
		PH_WS,
		PH_SIGNED,
		PH_ZERO,
		PH_ZEROB,
		PH_DIGITS,
		PH_SUF_I,
		PH_SUF_B,
		PH_SUF_END
	} sip_phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_OCT,
		RADIX_BIN
	} sip_radix_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_INVAL = 2'd1,
		ERR_RANGE = 2'd2
	} sip_err_t;

	// parse state as handed from the byte parser to the result stages
	typedef struct packed {
		sip_phase_t  phase;
		logic        neg;
		logic [63:0] mag;
		logic        saw_digit;
		sip_err_t    err;
		logic [5:0]  shift;
	} sip_snap_t;

	// largest magnitude allowed for the sign
	function automatic logic [63:0] mag_limit(input logic neg);
		return neg ? SignBit : PosLimit;
	endfunction

endpackage

// ===== hdl/sip_if.sv =====
// sip_if: valid/ready channels of the suffixed integer parser
// depends on nothing; used by the top level and the result stages
`timescale 1ns / 1ps

// text byte channel
interface sip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

// parse result channel
interface sip_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [1:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ===== hdl/sip_parse.sv =====
// sip_parse: per-byte parse state machine (whitespace, sign, radix, digits, suffix)
// depends on sip_pkg; hands the final state of each string to sip_final
`timescale 1ns / 1ps

module sip_parse import sip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] text_byte,
	input  logic       is_last,
	output logic       byte_ready,
	output logic       snap_valid,
	input  logic       snap_ready,
	output sip_snap_t  snap
);

	sip_snap_t  st_q;
	sip_radix_t radix_q;
	logic       ended_q;

	sip_snap_t  nx;
	sip_radix_t nx_radix;
	logic       nx_ended;

	logic       fire;
	logic [7:0] lc;
	logic       is_ws;
	logic       is_dec;
	logic [4:0] dval;
	sip_radix_t rad_eff;
	logic       dig_ok;
	logic [68:0] prod;
	logic       ovf;
	logic       suf_ok;
	logic [5:0] suf_shift;
	logic       start;
	logic       do_dig;
	logic       do_sufi;

	// handshake: a last byte waits for room in the result stages
	assign byte_ready = !is_last || snap_ready;
	assign fire       = byte_valid && byte_ready;
	assign snap_valid = byte_valid && is_last;
	assign snap       = nx;

	// character classes
	always_comb begin
		lc     = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;
		is_ws  = (text_byte == 8'd32) || (text_byte >= 8'd9 && text_byte <= 8'd13);
		is_dec = (text_byte >= "0" && text_byte <= "9");
		if (is_dec) begin
			dval = 5'(text_byte - "0");
		end else if (lc >= "a" && lc <= "f") begin
			dval = 5'(lc - "a" + 8'd10);
		end else begin
			dval = 5'h1f;
		end
	end

	// radix in force for a digit of this byte
	always_comb begin
		rad_eff = radix_q;
		if (st_q.phase == PH_ZERO && is_dec) begin
			rad_eff = RADIX_OCT;
		end else if (st_q.phase == PH_ZEROB) begin
			rad_eff = RADIX_BIN;
		end
	end

	// digit accumulate: shift-add by the radix, checked against the limit
	always_comb begin
		unique case (rad_eff)
			RADIX_DEC: begin
				dig_ok = dval < 5'd10;
				prod = ({5'b0, st_q.mag} << 3) + ({5'b0, st_q.mag} << 1);
			end
			RADIX_HEX: begin
				dig_ok = dval < 5'd16;
				prod = {5'b0, st_q.mag} << 4;
			end
			RADIX_OCT: begin
				dig_ok = dval < 5'd8;
				prod = {5'b0, st_q.mag} << 3;
			end
			RADIX_BIN: begin
				dig_ok = dval < 5'd2;
				prod = {5'b0, st_q.mag} << 1;
			end
		endcase
		prod = prod + {64'b0, dval};
		ovf  = prod > {5'b0, mag_limit(st_q.neg)};
	end

	// suffix letter lookup
	always_comb begin
		suf_ok = 1'b1;
		unique case (lc)
			"b":     suf_shift = 6'd9;
			"k":     suf_shift = 6'd10;
			"m":     suf_shift = 6'd20;
			"g":     suf_shift = 6'd30;
			"t":     suf_shift = 6'd40;
			"p":     suf_shift = 6'd50;
			"e":     suf_shift = 6'd60;
			"w":     suf_shift = 6'd2;
			default: begin
				suf_ok    = 1'b0;
				suf_shift = 6'd0;
			end
		endcase
	end

	// next parse state for this byte
	always_comb begin
		nx       = st_q;
		nx_radix = radix_q;
		nx_ended = ended_q;
		start    = 1'b0;
		do_dig   = 1'b0;
		do_sufi  = 1'b0;
		if (text_byte == 8'd0) begin
			nx_ended = 1'b1;
		end else if (!ended_q && st_q.err == ERR_NONE) begin
			unique case (st_q.phase)
				PH_WS: begin
					if (is_ws) begin
						nx.phase = PH_WS;
					end else if (text_byte == "+" || text_byte == "-") begin
						nx.neg   = (text_byte == "-");
						nx.phase = PH_SIGNED;
					end else begin
						start = 1'b1;
					end
				end
				PH_SIGNED: start = 1'b1;
				PH_ZERO: begin
					if (lc == "x") begin
						nx_radix = RADIX_HEX;
						nx.phase = PH_DIGITS;
					end else if (lc == "b") begin
						nx.phase = PH_ZEROB;
					end else begin
						nx.saw_digit = 1'b1;
						nx_radix     = rad_eff;
						nx.phase     = PH_DIGITS;
						do_dig       = 1'b1;
					end
				end
				PH_ZEROB: begin
					if (text_byte == "0" || text_byte == "1") begin
						nx_radix = RADIX_BIN;
						nx.phase = PH_DIGITS;
						do_dig   = 1'b1;
					end else begin
						nx.saw_digit = 1'b1;
						nx.shift     = 6'd9;
						nx.phase     = PH_SUF_I;
						do_sufi      = 1'b1;
					end
				end
				PH_DIGITS: do_dig  = 1'b1;
				PH_SUF_I:  do_sufi = 1'b1;
				PH_SUF_B: begin
					if (lc == "b") begin
						nx.phase = PH_SUF_END;
					end else begin
						nx.err = ERR_INVAL;
					end
				end
				default: nx.err = ERR_INVAL;
			endcase

			// first significant byte after whitespace and sign
			if (start) begin
				if (text_byte == "0") begin
					nx.phase = PH_ZERO;
				end else begin
					nx.phase = PH_DIGITS;
					do_dig   = 1'b1;
				end
			end

			// digit, or the suffix letter that ends the digits
			if (do_dig) begin
				if (dig_ok) begin
					nx.saw_digit = 1'b1;
					if (ovf) begin
						nx.err = ERR_RANGE;
					end else begin
						nx.mag = prod[63:0];
					end
				end else if (!nx.saw_digit) begin
					nx.err = ERR_INVAL;
				end else if (suf_ok) begin
					nx.shift = suf_shift;
					nx.phase = PH_SUF_I;
				end else begin
					nx.err = ERR_INVAL;
				end
			end

			// optional i, or the closing b
			if (do_sufi) begin
				if (lc == "i") begin
					nx.phase = PH_SUF_B;
				end else if (lc == "b") begin
					nx.phase = PH_SUF_END;
				end else begin
					nx.err = ERR_INVAL;
				end
			end
		end
	end

	// parse state, cleared after the last byte of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase     <= PH_WS;
			st_q.neg       <= 1'b0;
			st_q.mag       <= 64'd0;
			st_q.saw_digit <= 1'b0;
			st_q.err       <= ERR_NONE;
			st_q.shift     <= 6'd0;
			radix_q        <= RADIX_DEC;
			ended_q        <= 1'b0;
		end else if (fire) begin
			if (is_last) begin
				st_q.phase     <= PH_WS;
				st_q.neg       <= 1'b0;
				st_q.mag       <= 64'd0;
				st_q.saw_digit <= 1'b0;
				st_q.err       <= ERR_NONE;
				st_q.shift     <= 6'd0;
				radix_q        <= RADIX_DEC;
				ended_q        <= 1'b0;
			end else begin
				st_q     <= nx;
				radix_q  <= nx_radix;
				ended_q  <= nx_ended;
			end
		end
	end

`ifndef ASSERT_OFF
	// accumulated magnitude never passes the negative limit
	assert property (@(posedge clk) disable iff (!arst_n) st_q.mag <= SignBit)
		else $error("magnitude above limit");

	// a recorded error stays until the string ends
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.err != ERR_NONE && !(fire && is_last)) |=> st_q.err == $past(st_q.err))
		else $error("first error overwritten");

	// suffix phases are only reached with a suffix multiplier set
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_SUF_I || st_q.phase == PH_SUF_B || st_q.phase == PH_SUF_END)
		|-> st_q.shift != 6'd0)
		else $error("suffix phase without suffix");
`endif

endmodule

// ===== hdl/sip_final.sv =====
// sip_final: suffix scaling, sign and bounds check, result register
// depends on sip_pkg and sip_if; fed by sip_parse
`timescale 1ns / 1ps

module sip_final import sip_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               snap_valid,
	output logic               snap_ready,
	input  sip_snap_t          snap,
	input  logic signed [63:0] min_value,
	input  logic signed [63:0] max_value,
	sip_out_if.source          out_ch
);

	sip_snap_t   snap_s2;
	logic        vld_s2;
	sip_err_t    err_s3;
	logic [63:0] mag_s3;
	logic        neg_s3;
	logic        vld_s3;
	logic        vld_q;
	logic signed [63:0] value_q;
	sip_err_t    status_q;

	logic        rdy2;
	logic        rdy3;
	logic        rdy_o;
	sip_err_t    err_a;
	logic [63:0] mag_a;
	logic [63:0] lim_sh;
	logic signed [63:0] v_b;
	sip_err_t    err_b;

	// stage enables: each stage moves when the next has room
	assign rdy_o      = !vld_q || out_ch.ready;
	assign rdy3       = !vld_s3 || rdy_o;
	assign rdy2       = !vld_s2 || rdy3;
	assign snap_ready = rdy2;

	assign out_ch.valid  = vld_q;
	assign out_ch.value  = value_q;
	assign out_ch.status = status_q;

	// bounds order, empty number and suffix scaling
	always_comb begin
		err_a  = snap_s2.err;
		mag_a  = snap_s2.mag;
		lim_sh = mag_limit(snap_s2.neg) >> snap_s2.shift;
		if (min_value > max_value) begin
			err_a = ERR_INVAL;
		end else if (snap_s2.err == ERR_NONE) begin
			if (snap_s2.phase == PH_WS || snap_s2.phase == PH_SIGNED ||
			    (snap_s2.phase == PH_DIGITS && !snap_s2.saw_digit)) begin
				err_a = ERR_INVAL;
			end else if (snap_s2.shift != 6'd0 && snap_s2.mag > lim_sh) begin
				err_a = ERR_RANGE;
			end else begin
				mag_a = snap_s2.mag << snap_s2.shift;
			end
		end
	end

	// apply sign and check against min and max
	always_comb begin
		v_b   = 64'sd0;
		err_b = err_s3;
		if (err_s3 == ERR_NONE) begin
			v_b = neg_s3 ? $signed(64'd0 - mag_s3) : $signed(mag_s3);
			if (v_b < min_value || v_b > max_value) begin
				err_b = ERR_RANGE;
				v_b   = 64'sd0;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy2) begin
				vld_s2 <= snap_valid;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_o) begin
				vld_q <= vld_s3;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (snap_valid && rdy2) begin
			snap_s2 <= snap;
		end
		if (vld_s2 && rdy3) begin
			err_s3 <= err_a;
			mag_s3 <= mag_a;
			neg_s3 <= snap_s2.neg;
		end
		if (vld_s3 && rdy_o) begin
			value_q  <= v_b;
			status_q <= err_b;
		end
	end

endmodule

// ===== hdl/suffixed_integer_parser.sv =====
// suffixed_integer_parser: top level with input register, bounds registers,
// byte parser and result stages; depends on sip_pkg, sip_if, sip_parse, sip_final
`timescale 1ns / 1ps

// Usage
//   in_ch carries one text byte per item with is_last marking the final byte of
//   a string; out_ch carries one item (value, status) per string, produced by
//   the item whose is_last is set. A zero byte ends the string early; the
//   following bytes up to is_last are taken and ignored.
//   cfg_we/cfg_index/cfg_data write min_value (index 0) or max_value (index 1)
//   while the block is idle.
// Throughput: one byte per cycle, except while a last byte waits for room in the
//   result stages; the digit update is a single shift-add and limit compare per
//   byte. The result then passes the parse, suffix scaling and bounds check stages.
// Stalls: bytes that are not last keep flowing while a result waits; a last
//   byte waits only when all three result stages are full.
// Reset: arst_n clears the parse state, empties all stages and sets the bounds
//   to the full signed 64-bit range.

module suffixed_integer_parser import sip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sip_in_if.sink      in_ch,
	sip_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               vld_s1;
	logic signed [63:0] min_q;
	logic signed [63:0] max_q;

	logic       byte_ready;
	logic       fire1;
	logic       snap_valid;
	logic       snap_ready;
	sip_snap_t  snap;

	// input register
	assign fire1       = vld_s1 && byte_ready;
	assign in_ch.ready = !vld_s1 || byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			vld_s1 <= 1'b1;
		end else if (fire1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.text_byte;
			last_s1 <= in_ch.is_last;
		end
	end

	// bounds registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= $signed(SignBit);
			max_q <= $signed(PosLimit);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgMinIdx: min_q <= $signed(cfg_data);
				CfgMaxIdx: max_q <= $signed(cfg_data);
			endcase
		end
	end

	sip_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (vld_s1),
		.text_byte  (byte_s1),
		.is_last    (last_s1),
		.byte_ready (byte_ready),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	sip_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.min_value  (min_q),
		.max_value  (max_q),
		.out_ch     (out_ch)
	);

`ifndef ASSERT_OFF
	// an error result always carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != ERR_NONE) |-> out_ch.value == 64'sd0)
		else $error("nonzero value on error");

	// a good result lies within the configured bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ERR_NONE)
		|-> (out_ch.value >= min_q && out_ch.value <= max_q))
		else $error("result outside bounds");

	// a good result never comes from inverted bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ERR_NONE) |-> min_q <= max_q)
		else $error("result accepted with inverted bounds");
`endif

endmodule

// ===== tb/suffixed_integer_parser_tb.sv =====
// suffixed_integer_parser_tb: self-checking testbench of the suffixed integer parser
// feeds text strings byte by byte and checks every (value, status) item against
// its parse model or a directed case's item; depends on sip_pkg, sip_if, suffixed_integer_parser
`timescale 1ns / 1ps

module suffixed_integer_parser_tb;
	import sip_pkg::*;

	localparam logic signed [63:0] S64_MAX = PosLimit;
	localparam logic signed [63:0] S64_MIN = SignBit;
	localparam int unsigned NOT_DIGIT = 99;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_LEN = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 40;
	localparam int PHASE_BYTES = 118;

	// bound settings used by the directed cases
	localparam logic [1:0] BND_FULL = 2'd0;
	localparam logic [1:0] BND_NARROW = 2'd1;
	localparam logic [1:0] BND_SWAPPED = 2'd2;

	typedef struct packed {
		logic signed [63:0] value;
		sip_err_t status;
	} parse_result_t;

	typedef struct packed {
		logic [1:0] bounds;
		logic known;
		logic signed [63:0] value;
		sip_err_t status;
	} case_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [63:0] cfg_data;

	sip_in_if text_ch();
	sip_out_if result_ch();

	suffixed_integer_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(text_ch),
		.out_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// parse model state and bounds
	sip_phase_t p_phase;
	sip_radix_t p_radix;
	sip_err_t p_err;
	logic p_neg;
	logic p_saw;
	logic p_ended;
	logic [63:0] p_mag;
	logic [5:0] p_shift;
	logic signed [63:0] lo_bound;
	logic signed [63:0] hi_bound;

	parse_result_t pending_results[$];
	logic [7:0] text_q[$];
	string case_text[$];
	case_row_t case_rows[$];

	int error_count = 0;
	int strings_sent = 0;
	int bytes_sent = 0;
	int status_seen[3] = '{0, 0, 0};
	int quiet_cycles = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int stall_left = 0;
	bit src_idle = 1'b0;
	bit sink_idle = 1'b0;

	// ---------------------------------------------------------------- parse model

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int unsigned digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return NOT_DIGIT;
	endfunction

	function automatic void clear_parse();
		p_phase = PH_WS;
		p_neg = 1'b0;
		p_radix = RADIX_DEC;
		p_mag = '0;
		p_saw = 1'b0;
		p_err = ERR_NONE;
		p_shift = '0;
		p_ended = 1'b0;
	endfunction

	// multiplier letter: shift amount of the scale
	function automatic void take_suffix(logic [7:0] c);
		case (fold_case(c))
			"b": p_shift = 6'd9;
			"k": p_shift = 6'd10;
			"m": p_shift = 6'd20;
			"g": p_shift = 6'd30;
			"t": p_shift = 6'd40;
			"p": p_shift = 6'd50;
			"e": p_shift = 6'd60;
			"w": p_shift = 6'd2;
			default: begin
				p_err = ERR_INVAL;
				return;
			end
		endcase
		p_phase = PH_SUF_I;
	endfunction

	// optional i or b after the multiplier letter
	function automatic void after_suffix(logic [7:0] c);
		if (fold_case(c) == "i") p_phase = PH_SUF_B;
		else if (fold_case(c) == "b") p_phase = PH_SUF_END;
		else p_err = ERR_INVAL;
	endfunction

	// digit accumulate with overflow against the signed magnitude
	function automatic void feed_digit(logic [7:0] c);
		logic [63:0] base;
		logic [63:0] d;
		logic [63:0] lim;
		case (p_radix)
			RADIX_HEX: base = 64'd16;
			RADIX_OCT: base = 64'd8;
			RADIX_BIN: base = 64'd2;
			default: base = 64'd10;
		endcase
		d = 64'(digit_of(c));
		lim = p_neg ? SignBit : PosLimit;
		if (d < base) begin
			p_saw = 1'b1;
			if (p_mag > (lim - d) / base) p_err = ERR_RANGE;
			else p_mag = p_mag * base + d;
		end else if (!p_saw) begin
			p_err = ERR_INVAL;
		end else begin
			take_suffix(c);
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		case (p_phase)
			PH_WS, PH_SIGNED: begin
				if (p_phase == PH_WS && (c == " " || (c >= 8'd9 && c <= 8'd13))) return;
				if (p_phase == PH_WS && (c == "+" || c == "-")) begin
					p_neg = (c == "-");
					p_phase = PH_SIGNED;
					return;
				end
				if (c == "0") begin
					p_phase = PH_ZERO;
				end else begin
					p_phase = PH_DIGITS;
					feed_digit(c);
				end
			end
			PH_ZERO: begin
				if (fold_case(c) == "x") begin
					p_radix = RADIX_HEX;
					p_phase = PH_DIGITS;
				end else if (fold_case(c) == "b") begin
					p_phase = PH_ZEROB;
				end else begin
					p_saw = 1'b1;
					if (c >= "0" && c <= "9") p_radix = RADIX_OCT;
					p_phase = PH_DIGITS;
					feed_digit(c);
				end
			end
			PH_ZEROB: begin
				if (c == "0" || c == "1") begin
					p_radix = RADIX_BIN;
					p_phase = PH_DIGITS;
					feed_digit(c);
				end else begin
					// the b was a 512 suffix on a plain zero
					p_saw = 1'b1;
					p_shift = 6'd9;
					p_phase = PH_SUF_I;
					after_suffix(c);
				end
			end
			PH_DIGITS: feed_digit(c);
			PH_SUF_I: after_suffix(c);
			PH_SUF_B: begin
				if (fold_case(c) == "b") p_phase = PH_SUF_END;
				else p_err = ERR_INVAL;
			end
			default: p_err = ERR_INVAL;
		endcase
	endfunction

	// one byte in; returns 1 with the result item when the byte is last
	function automatic bit parse_byte(logic [7:0] c, logic last, output parse_result_t r);
		logic [63:0] m;
		logic [63:0] lim;
		logic signed [63:0] v;
		sip_err_t st;
		r = '0;
		if (!p_ended && p_err == ERR_NONE) begin
			if (c == 8'h00) p_ended = 1'b1;
			else parse_char(c);
		end else if (c == 8'h00) begin
			p_ended = 1'b1;
		end
		if (!last) return 1'b0;

		st = p_err;
		m = p_mag;
		lim = p_neg ? SignBit : PosLimit;
		if (lo_bound > hi_bound) begin
			st = ERR_INVAL;
		end else if (st == ERR_NONE) begin
			if (p_phase == PH_WS || p_phase == PH_SIGNED || (p_phase == PH_DIGITS && !p_saw))
				st = ERR_INVAL;
			else if (p_shift != 0 && m > (lim >> p_shift))
				st = ERR_RANGE;
			else
				m = m << p_shift;
		end
		v = '0;
		if (st == ERR_NONE) begin
			v = p_neg ? 64'(-m) : m;
			if (v < lo_bound || v > hi_bound) begin
				st = ERR_RANGE;
				v = '0;
			end
		end
		r.value = v;
		r.status = st;
		clear_parse();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_char(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	function automatic void add_case(string t, logic [1:0] bnd, logic known,
			logic signed [63:0] val, sip_err_t st);
		case_row_t row;
		row.bounds = bnd;
		row.known = known;
		row.value = val;
		row.status = st;
		case_text.push_back(t);
		case_rows.push_back(row);
	endfunction

	// random string: mostly well-formed numbers, some noise and damage
	function automatic void build_text();
		int unsigned r;
		int unsigned nd;
		int unsigned k;
		bit long_num;
		text_q.delete();
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (r < 16) begin
			case ($urandom_range(0, 5))
				0: push_str("9223372036854775807");
				1: push_str("-9223372036854775808");
				2: push_str("0x7fffffffffffffff");
				3: push_str("-0X8000000000000000");
				4: push_str("-0");
				default: push_str("7e");
			endcase
			return;
		end

		// leading whitespace and sign
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				k = $urandom_range(9, 14);
				text_q.push_back(k == 14 ? " " : 8'(k));
			end
		end
		case ($urandom_range(0, 3))
			2: text_q.push_back("+");
			3: text_q.push_back("-");
			default: ;
		endcase

		// radix prefix and digits
		long_num = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 3))
			0: begin
				nd = long_num ? $urandom_range(18, 21) : $urandom_range(1, 4);
				text_q.push_back(pick_char("123456789"));
				repeat (nd - 1) text_q.push_back(pick_char("0123456789"));
			end
			1: begin
				push_str("0");
				text_q.push_back(pick_char("xX"));
				nd = long_num ? $urandom_range(15, 17) : $urandom_range(1, 4);
				repeat (nd) text_q.push_back(pick_char("0123456789abcdefABCDEF"));
			end
			2: begin
				push_str("0");
				nd = long_num ? $urandom_range(20, 22) : $urandom_range(1, 3);
				repeat (nd) text_q.push_back(pick_char("01234567"));
			end
			default: begin
				push_str("0");
				text_q.push_back(pick_char("bB"));
				nd = long_num ? $urandom_range(62, 64) : $urandom_range(1, 6);
				repeat (nd) text_q.push_back(pick_char("01"));
			end
		endcase

		// optional multiplier suffix
		if ($urandom_range(0, 4) < 2) begin
			text_q.push_back(pick_char("bkmgtpewBKMGTPEW"));
			if ($urandom_range(0, 1) == 1) text_q.push_back(pick_char("iI"));
			if ($urandom_range(0, 1) == 1) text_q.push_back(pick_char("bB"));
		end

		// damage a few strings
		if ($urandom_range(0, 99) < 15) begin
			k = $urandom_range(0, text_q.size() - 1);
			case ($urandom_range(0, 3))
				0: text_q[k] = 8'($urandom_range(0, 255));
				1: text_q.insert(k, 8'h00);
				2: while (text_q.size() > k) void'(text_q.pop_back());
				default: text_q.push_back(pick_char("0123456789xzq."));
			endcase
		end
		if (text_q.size() == 0) text_q.push_back(8'h00);
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic push_byte(input logic [7:0] b, input logic last,
			output bit got, output parse_result_t r);
		int gap;
		gap = src_idle ? idle_len() : 0;
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.is_last <= last;
		do @(posedge clk); while (!text_ch.ready);
		bytes_sent++;
		got = parse_byte(b, last, r);
		@(negedge clk);
	endtask

	// sends text_q; a directed row may supply its own expected item
	task automatic send_text(input bit use_row, input parse_result_t row_res);
		bit got;
		parse_result_t r;
		for (int i = 0; i < text_q.size(); i++) begin
			push_byte(text_q[i], i == text_q.size() - 1, got, r);
			if (got) pending_results.push_back(use_row ? row_res : r);
		end
		strings_sent++;
	endtask

	task automatic wait_idle();
		text_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_bounds(input logic signed [63:0] lo, input logic signed [63:0] hi);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CfgMinIdx;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CfgMaxIdx;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		lo_bound = lo;
		hi_bound = hi;
	endtask

	// result side ready: random stalls plus a long hold on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			if (hold_asked != hold_done) begin
				stall_left = HOLD_LEN;
				hold_done++;
			end else if (sink_idle) begin
				stall_left = idle_len();
			end
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void report_mismatch(string field, logic signed [63:0] want,
			logic signed [63:0] got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
	endfunction

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$error("item with nothing expected: value %0d, status %0d",
						result_ch.value, result_ch.status);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.value !== want.value)
					report_mismatch("value", want.value, result_ch.value);
				if (result_ch.status !== want.status)
					report_mismatch("status", 64'(want.status), 64'(result_ch.status));
				status_seen[want.status]++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		case_row_t row;
		parse_result_t row_res;
		logic [1:0] cur_bounds;
		logic signed [63:0] a;
		logic signed [63:0] b;
		int budget;
		logic [7:0] c;

		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.is_last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgMinIdx;
		cfg_data = '0;
		lo_bound = S64_MIN;
		hi_bound = S64_MAX;
		clear_parse();

		// directed cases; a tilde stands for a zero byte
		add_case("0", BND_FULL, 1, 0, ERR_NONE);
		add_case("9223372036854775807", BND_FULL, 1, S64_MAX, ERR_NONE);
		add_case("-9223372036854775808", BND_FULL, 1, S64_MIN, ERR_NONE);
		add_case("9223372036854775808", BND_FULL, 1, 0, ERR_RANGE);
		add_case("\t\n +42", BND_FULL, 1, 42, ERR_NONE);
		add_case("-0X8000000000000000", BND_FULL, 0, 0, ERR_NONE);
		add_case("0x", BND_FULL, 1, 0, ERR_INVAL);
		add_case("0b101", BND_FULL, 0, 0, ERR_NONE);
		add_case("0BiB", BND_FULL, 0, 0, ERR_NONE);
		add_case("0777", BND_FULL, 0, 0, ERR_NONE);
		add_case("089", BND_FULL, 1, 0, ERR_INVAL);
		add_case("3KiB", BND_FULL, 0, 0, ERR_NONE);
		add_case("5mI", BND_FULL, 0, 0, ERR_NONE);
		add_case("7g", BND_FULL, 0, 0, ERR_NONE);
		add_case("2Tb", BND_FULL, 0, 0, ERR_NONE);
		add_case("1p", BND_FULL, 0, 0, ERR_NONE);
		add_case("-8E", BND_FULL, 0, 0, ERR_NONE);
		add_case("9W", BND_FULL, 0, 0, ERR_NONE);
		add_case("4b", BND_FULL, 0, 0, ERR_NONE);
		add_case("8e", BND_FULL, 1, 0, ERR_RANGE);
		add_case("1kib7", BND_FULL, 1, 0, ERR_INVAL);
		add_case("~", BND_FULL, 1, 0, ERR_INVAL);
		add_case(" -", BND_FULL, 1, 0, ERR_INVAL);
		add_case("12~zq", BND_FULL, 0, 0, ERR_NONE);
		add_case("99999999999999999999q", BND_FULL, 1, 0, ERR_RANGE);
		add_case("-1", BND_NARROW, 1, 0, ERR_RANGE);
		add_case("99999999999999999999", BND_SWAPPED, 1, 0, ERR_INVAL);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		src_idle = 1'b1;
		sink_idle <= 1'b1;
		cur_bounds = BND_FULL;
		for (int i = 0; i < case_rows.size(); i++) begin
			row = case_rows[i];
			if (row.bounds != cur_bounds) begin
				case (row.bounds)
					BND_NARROW: set_bounds(0, 100);
					BND_SWAPPED: set_bounds(1, 0);
					default: set_bounds(S64_MIN, S64_MAX);
				endcase
				cur_bounds = row.bounds;
			end
			text_q.delete();
			for (int j = 0; j < case_text[i].len(); j++) begin
				c = case_text[i][j];
				text_q.push_back(c == "~" ? 8'h00 : c);
			end
			row_res.value = row.value;
			row_res.status = row.status;
			send_text(row.known, row_res);
		end

		// random part, one bound setting per phase
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				1: set_bounds(0, 1000);
				2: set_bounds(S64_MIN, S64_MIN);
				3: set_bounds(S64_MAX, S64_MAX);
				4: set_bounds(S64_MAX, S64_MIN);
				5: begin
					a = {$urandom, $urandom};
					b = {$urandom, $urandom};
					if ($urandom_range(0, 3) != 0 && a > b) set_bounds(b, a);
					else set_bounds(a, b);
				end
				6: set_bounds(-64'sd1 * $urandom_range(0, 5000), $urandom_range(0, 5000));
				default: set_bounds(S64_MIN, S64_MAX);
			endcase
			src_idle = (ph != 2);
			sink_idle <= (ph != 2);
			if (ph == 0) begin
				// receiver holds off while bytes keep coming
				src_idle = 1'b0;
				hold_asked <= hold_asked + 1;
			end
			budget = bytes_sent + PHASE_BYTES;
			while (bytes_sent < budget) begin
				build_text();
				send_text(1'b0, '0);
			end
		end

		wait_idle();
		$display("covered %0d strings (%0d bytes) over directed cases and 8 bound settings",
			strings_sent, bytes_sent);
		$display("items checked: %0d ok, %0d invalid, %0d out of range",
			status_seen[ERR_NONE], status_seen[ERR_INVAL], status_seen[ERR_RANGE]);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/sip_pkg.sv
hdl/sip_if.sv
hdl/sip_parse.sv
hdl/sip_final.sv
hdl/suffixed_integer_parser.sv
tb/suffixed_integer_parser_tb.sv
